### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the finite-difference block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/bdd_pkg.sv
// ----------------------------------------------------------------------------
// bdd_pkg
// Types, widths and the binomial coefficient table of the finite-difference block.
// ----------------------------------------------------------------------------
package bdd_pkg;

    localparam int unsigned CHANNELS_DEF     = 16;
    localparam int unsigned MAX_ORDER_DEF    = 8;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;

    localparam int unsigned CHANNEL_W   = 4;
    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned RESULT_W    = 64;
    localparam int unsigned ORDER_REG_W = 4;
    localparam int unsigned INV_DT_W    = 48;

    localparam int unsigned PADDR_W       = 4;
    localparam int unsigned PDATA_W       = 64;
    localparam int unsigned REG_ADDR_LSB  = 3;

    // Scaling multiplier: 64-bit magnitude times 48-bit factor, in 32x24 pieces.
    localparam int unsigned MAG_W       = 64;
    localparam int unsigned MAG_HALF_W  = 32;
    localparam int unsigned K_HALF_W    = 24;
    localparam int unsigned PP_W        = MAG_HALF_W + K_HALF_W;
    localparam int unsigned SPROD_W     = MAG_W + INV_DT_W;
    localparam int unsigned FRAC_DROP   = 16;
    localparam int unsigned SCALE_PARTS = 4;

    localparam logic [SPROD_W-1:0] RND_POS = SPROD_W'(32'h8000);
    localparam logic [SPROD_W-1:0] RND_NEG = SPROD_W'(32'h7FFF);
    localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    localparam int unsigned COEF_W      = 16;
    localparam int unsigned BINOM_ROWS  = 17;
    localparam int unsigned BINOM_IDX_W = 5;

    localparam logic [COEF_W-1:0] BINOM_TAB [BINOM_ROWS][BINOM_ROWS] = '{
        '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 3, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 4, 6, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 5, 10, 10, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 6, 15, 20, 15, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 7, 21, 35, 35, 21, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 8, 28, 56, 70, 56, 28, 8, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 9, 36, 84, 126, 126, 84, 36, 9, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, 10, 45, 120, 210, 252, 210, 120, 45, 10, 1, 0, 0, 0, 0, 0, 0},
        '{1, 11, 55, 165, 330, 462, 462, 330, 165, 55, 11, 1, 0, 0, 0, 0, 0},
        '{1, 12, 66, 220, 495, 792, 924, 792, 495, 220, 66, 12, 1, 0, 0, 0, 0},
        '{1, 13, 78, 286, 715, 1287, 1716, 1716, 1287, 715, 286, 78, 13, 1, 0, 0, 0},
        '{1, 14, 91, 364, 1001, 2002, 3003, 3432, 3003, 2002, 1001, 364, 91, 14, 1,
          0, 0},
        '{1, 15, 105, 455, 1365, 3003, 5005, 6435, 6435, 5005, 3003, 1365, 455, 105,
          15, 1, 0},
        '{1, 16, 120, 560, 1820, 4368, 8008, 11440, 12870, 11440, 8008, 4368, 1820,
          560, 120, 16, 1}
    };

    typedef struct packed {
        logic [ORDER_REG_W-1:0] diff_order;
        logic [INV_DT_W-1:0]    inv_dt_power;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } scale_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic                sat;
        logic [RESULT_W-1:0] value;
    } scale_sts_t;

endpackage

### hdl/bdd_ifs.sv
// ----------------------------------------------------------------------------
// bdd_in_if / bdd_out_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface bdd_in_if;
    logic                                valid;
    logic                                ready;
    logic [bdd_pkg::CHANNEL_W-1:0]       channel;
    logic signed [bdd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface bdd_out_if;
    logic                                valid;
    logic                                ready;
    logic [bdd_pkg::CHANNEL_W-1:0]       out_channel;
    logic signed [bdd_pkg::RESULT_W-1:0] offset;
    logic signed [bdd_pkg::RESULT_W-1:0] derivative;
    logic                                saturated;

    modport source (output valid, output out_channel, output offset, output derivative,
                    output saturated, input ready);
    modport sink   (input valid, input out_channel, input offset, input derivative,
                    input saturated, output ready);
endinterface

### hdl/bdd_cfg.sv
// ----------------------------------------------------------------------------
// bdd_cfg
// APB-style register file holding the difference order and 1/dt^n factor.
// ----------------------------------------------------------------------------
module bdd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdd_pkg::PADDR_W-1:0]  paddr,
    input  logic [bdd_pkg::PDATA_W-1:0]  pwdata,
    output logic [bdd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bdd_pkg::cfg_t                cfg
);

    localparam int unsigned IDX_W = bdd_pkg::PADDR_W - bdd_pkg::REG_ADDR_LSB;

    localparam logic [IDX_W-1:0] REG_DIFF_ORDER   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_INV_DT_POWER = IDX_W'(1);

    localparam logic [bdd_pkg::ORDER_REG_W-1:0] ORDER_RST  = bdd_pkg::ORDER_REG_W'(1);
    localparam logic [bdd_pkg::INV_DT_W-1:0]    INV_DT_RST = bdd_pkg::INV_DT_W'(65536);

    logic [IDX_W-1:0]                  reg_idx;
    logic                              wr_en;
    logic [bdd_pkg::ORDER_REG_W-1:0]   diff_order_reg;
    logic [bdd_pkg::INV_DT_W-1:0]      inv_dt_power_reg;

    assign reg_idx = paddr[bdd_pkg::PADDR_W-1:bdd_pkg::REG_ADDR_LSB];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_order_reg   <= ORDER_RST;
            inv_dt_power_reg <= INV_DT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DIFF_ORDER:
                    diff_order_reg <= pwdata[bdd_pkg::ORDER_REG_W-1:0];
                REG_INV_DT_POWER:
                    inv_dt_power_reg <= pwdata[bdd_pkg::INV_DT_W-1:0];
                default:
                    diff_order_reg <= diff_order_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DIFF_ORDER:   prdata = bdd_pkg::PDATA_W'(diff_order_reg);
            REG_INV_DT_POWER: prdata = bdd_pkg::PDATA_W'(inv_dt_power_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.diff_order   = diff_order_reg;
    assign cfg.inv_dt_power = inv_dt_power_reg;

endmodule

### hdl/bdd_hist_mem.sv
// ----------------------------------------------------------------------------
// bdd_hist_mem
// Simple dual-port history memory with a registered read port.
// ----------------------------------------------------------------------------
module bdd_hist_mem #(
    parameter int unsigned ADDR_W = 7,
    parameter int unsigned DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bdd_scale.sv
// ----------------------------------------------------------------------------
// bdd_scale
// Multi-cycle signed-magnitude scaler: Q.16 rounding and 64-bit saturation.
// ----------------------------------------------------------------------------
module bdd_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdd_pkg::scale_req_t           req,
    input  logic [bdd_pkg::INV_DT_W-1:0]  k,
    output bdd_pkg::scale_sts_t           sts
);

    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_PARTS = CNT_W'(bdd_pkg::SCALE_PARTS);
    localparam logic [CNT_W-1:0] CNT_FIN   = CNT_W'(bdd_pkg::SCALE_PARTS + 1);
    localparam int unsigned Q_LO_MSB = bdd_pkg::FRAC_DROP + bdd_pkg::RESULT_W - 1;

    logic                               busy_reg;
    logic                               done_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic                               pp_vld_reg;
    logic [1:0]                         pp_idx_reg;
    logic                               neg_reg;
    logic [bdd_pkg::MAG_W-1:0]          mag_reg;
    logic [bdd_pkg::PP_W-1:0]           pp_reg;
    logic [bdd_pkg::SPROD_W-1:0]        prod_reg;
    logic                               sat_reg;
    logic [bdd_pkg::RESULT_W-1:0]       value_reg;

    logic [bdd_pkg::MAG_HALF_W-1:0]     mag_half;
    logic [bdd_pkg::K_HALF_W-1:0]       k_half;
    logic [bdd_pkg::PP_W-1:0]           pp_c;
    logic [bdd_pkg::SPROD_W-1:0]        pp_ext;
    logic [bdd_pkg::SPROD_W-Q_LO_MSB-2:0] q_hi;
    logic [bdd_pkg::RESULT_W-1:0]       q_lo;
    logic                               sat_c;
    logic [bdd_pkg::RESULT_W-1:0]       value_c;

    assign mag_half = cnt_reg[1] ? mag_reg[bdd_pkg::MAG_W-1:bdd_pkg::MAG_HALF_W]
                                 : mag_reg[bdd_pkg::MAG_HALF_W-1:0];
    assign k_half   = cnt_reg[0] ? k[bdd_pkg::INV_DT_W-1:bdd_pkg::K_HALF_W]
                                 : k[bdd_pkg::K_HALF_W-1:0];
    assign pp_c     = bdd_pkg::PP_W'(mag_half) * bdd_pkg::PP_W'(k_half);

    // Each partial product lands at the sum of its two halves' weights.
    always_comb
    begin
        case (pp_idx_reg)
            2'd0:    pp_ext = bdd_pkg::SPROD_W'(pp_reg);
            2'd1:    pp_ext = bdd_pkg::SPROD_W'(pp_reg) << bdd_pkg::K_HALF_W;
            2'd2:    pp_ext = bdd_pkg::SPROD_W'(pp_reg) << bdd_pkg::MAG_HALF_W;
            2'd3:    pp_ext = bdd_pkg::SPROD_W'(pp_reg) << bdd_pkg::PP_W;
            default: pp_ext = '0;
        endcase
    end

    // The rounding constant was preloaded, so dropping the fraction bits is enough.
    assign q_hi = prod_reg[bdd_pkg::SPROD_W-1:Q_LO_MSB+1];
    assign q_lo = prod_reg[Q_LO_MSB:bdd_pkg::FRAC_DROP];

    always_comb
    begin
        if (neg_reg)
        begin
            sat_c   = (|q_hi) || (q_lo[bdd_pkg::RESULT_W-1] && (|q_lo[bdd_pkg::RESULT_W-2:0]));
            value_c = sat_c ? bdd_pkg::RES_MIN : (~q_lo + bdd_pkg::RESULT_W'(1));
        end
        else
        begin
            sat_c   = (|q_hi) || q_lo[bdd_pkg::RESULT_W-1];
            value_c = sat_c ? bdd_pkg::RES_MAX : q_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg    <= cnt_reg + CNT_W'(1);
                pp_vld_reg <= (cnt_reg < CNT_PARTS);
                if (cnt_reg == CNT_FIN)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= req.neg;
            mag_reg  <= req.mag;
            prod_reg <= req.neg ? bdd_pkg::RND_NEG : bdd_pkg::RND_POS;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < CNT_PARTS)
            begin
                pp_reg     <= pp_c;
                pp_idx_reg <= cnt_reg[1:0];
            end
            if (pp_vld_reg)
            begin
                prod_reg <= prod_reg + pp_ext;
            end
            if (cnt_reg == CNT_FIN)
            begin
                sat_reg   <= sat_c;
                value_reg <= value_c;
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign sts.sat   = sat_reg;
    assign sts.value = value_reg;

endmodule

### hdl/backward_difference_derivative.sv
// ----------------------------------------------------------------------------
// backward_difference_derivative
// Per-channel nth-order backward finite difference with scaling and saturation.
// ----------------------------------------------------------------------------
// One sample item is worked on at a time. From acceptance to a result in the
// output register the history taps are read in turn on the read port of the
// history memory, the multiply-accumulate pipeline is drained and the new
// sample stored, two passes run through the four-step 32x24 scaling multiplier
// (history term, then full derivative) and the output register is loaded once
// any result held there has been taken. The next item can be accepted once the
// output register is loaded; a waiting result does not stop it being accepted.
// After reset the history memory is cleared one entry per cycle; no item is
// accepted until that is done, though register writes are taken throughout.
// A diff_order of 0 acts as 1 and one above MAX_ORDER acts as MAX_ORDER; a
// channel at or above CHANNELS uses the history of channel mod CHANNELS.
module backward_difference_derivative #(
    parameter int unsigned CHANNELS     = bdd_pkg::CHANNELS_DEF,
    parameter int unsigned MAX_ORDER    = bdd_pkg::MAX_ORDER_DEF,
    parameter int unsigned SAMPLE_WIDTH = bdd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bdd_in_if.sink                       samples,
    bdd_out_if.source                    results,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdd_pkg::PADDR_W-1:0]  paddr,
    input  logic [bdd_pkg::PDATA_W-1:0]  pwdata,
    output logic [bdd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

`include "assert_macros.svh"

    localparam int unsigned CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned TAP_AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int unsigned MEM_AW  = CH_AW + TAP_AW;
    localparam int unsigned ORD_W   = $clog2(MAX_ORDER + 1);
    localparam int unsigned ACC_W   = SAMPLE_WIDTH + MAX_ORDER + 1;
    localparam int unsigned PROD_W  = SAMPLE_WIDTH + bdd_pkg::COEF_W + 1;
    localparam int unsigned XW      = (SAMPLE_WIDTH > bdd_pkg::SAMPLE_W) ? SAMPLE_WIDTH
                                                                        : bdd_pkg::SAMPLE_W;
    localparam int unsigned IDX_W   = bdd_pkg::BINOM_IDX_W;
    localparam int unsigned CH_IN_N = 2 ** bdd_pkg::CHANNEL_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_SCALE_OFF,
        S_SCALE_DER,
        S_PUSH
    } state_t;

    bdd_pkg::cfg_t          cfg;
    bdd_pkg::scale_req_t    scale_req_reg;
    bdd_pkg::scale_req_t    scale_req_next;
    bdd_pkg::scale_sts_t    scale_sts;

    state_t                           state_reg;
    logic [MEM_AW-1:0]                clr_addr_reg;
    logic [TAP_AW-1:0]                rd_tap_reg;
    logic                             s1_vld_reg;
    logic                             s2_vld_reg;
    logic                             out_vld_reg;
    logic                             out_vld_next;

    logic [bdd_pkg::CHANNEL_W-1:0]    ch_in_reg;
    logic [CH_AW-1:0]                 mch_reg;
    logic signed [SAMPLE_WIDTH-1:0]   x_reg;
    logic [ORD_W-1:0]                 n_reg;
    logic [TAP_AW-1:0]                s1_tap_reg;
    logic signed [ACC_W-1:0]          prod_reg;
    logic                             s2_neg_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          der_acc_reg;
    logic [bdd_pkg::RESULT_W-1:0]     off_res_reg;
    logic                             off_sat_reg;
    logic [bdd_pkg::RESULT_W-1:0]     der_res_reg;
    logic                             der_sat_reg;
    logic [bdd_pkg::CHANNEL_W-1:0]    out_ch_reg;
    logic [bdd_pkg::RESULT_W-1:0]     out_off_reg;
    logic [bdd_pkg::RESULT_W-1:0]     out_der_reg;
    logic                             out_sat_reg;

    logic [CH_AW-1:0]                 ch_map [CH_IN_N];
    logic [XW-1:0]                    smp_zx;
    logic [IDX_W-1:0]                 ord_raw;
    logic [IDX_W-1:0]                 n_eff;
    logic [IDX_W-1:0]                 n5;
    logic [IDX_W-1:0]                 j5;
    logic [bdd_pkg::COEF_W-1:0]       coef;
    logic signed [bdd_pkg::COEF_W:0]  coef_s;
    logic signed [PROD_W-1:0]         prod_c;
    logic                             accept;
    logic                             drain_done;
    logic                             push_fire;
    logic                             shift_wr;
    logic [ACC_W-1:0]                 off_abs;
    logic [ACC_W-1:0]                 der_abs;

    logic                             mem_we;
    logic [MEM_AW-1:0]                mem_waddr;
    logic [SAMPLE_WIDTH-1:0]          mem_wdata;
    logic                             mem_re;
    logic [MEM_AW-1:0]                mem_raddr;
    logic [SAMPLE_WIDTH-1:0]          mem_rdata;

    bdd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdd_hist_mem #(
        .ADDR_W (MEM_AW),
        .DATA_W (SAMPLE_WIDTH)
    ) u_hist_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bdd_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req_reg),
        .k     (cfg.inv_dt_power),
        .sts   (scale_sts)
    );

    // Channel fold, worked out per input code at elaboration.
    for (genvar g = 0; g < CH_IN_N; g++)
    begin : g_ch_map
        localparam int unsigned MAPPED = g % CHANNELS;
        assign ch_map[g] = CH_AW'(MAPPED);
    end

    assign smp_zx  = XW'($unsigned(samples.sample));
    assign ord_raw = IDX_W'(cfg.diff_order);

    always_comb
    begin
        if (ord_raw == '0)
        begin
            n_eff = IDX_W'(1);
        end
        else if (ord_raw > IDX_W'(MAX_ORDER))
        begin
            n_eff = IDX_W'(MAX_ORDER);
        end
        else
        begin
            n_eff = ord_raw;
        end
    end

    assign accept     = samples.valid && samples.ready;
    assign drain_done = (state_reg == S_DRAIN) && !s1_vld_reg && !s2_vld_reg;
    assign push_fire  = (state_reg == S_PUSH) && (!out_vld_reg || results.ready);

    // Taps are read from the oldest down, so tap j-1 can be moved into tap j
    // as soon as its data returns; tap j has already been read by then.
    assign n5       = IDX_W'(n_reg);
    assign j5       = IDX_W'(s1_tap_reg) + IDX_W'(1);
    assign coef     = bdd_pkg::BINOM_TAB[n5][j5];
    assign coef_s   = {1'b0, coef};
    assign prod_c   = $signed(mem_rdata) * coef_s;
    assign shift_wr = s1_vld_reg && (j5 < n5);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {mch_reg, TAP_AW'(0)};
        mem_wdata = x_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (shift_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = {mch_reg, TAP_AW'(j5)};
            mem_wdata = mem_rdata;
        end
        else if (drain_done)
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = (state_reg == S_READ);
    assign mem_raddr = {mch_reg, rd_tap_reg};

    assign off_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign der_abs = der_acc_reg[ACC_W-1] ? ACC_W'(-der_acc_reg) : ACC_W'(der_acc_reg);

    // The scaler start is a single-cycle pulse; the operands are held after it.
    always_comb
    begin
        scale_req_next       = scale_req_reg;
        scale_req_next.start = 1'b0;
        if (drain_done)
        begin
            scale_req_next = '{start: 1'b1, neg: acc_reg[ACC_W-1],
                               mag: bdd_pkg::MAG_W'(off_abs)};
        end
        else if ((state_reg == S_SCALE_OFF) && scale_sts.done)
        begin
            scale_req_next = '{start: 1'b1, neg: der_acc_reg[ACC_W-1],
                               mag: bdd_pkg::MAG_W'(der_abs)};
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && results.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (push_fire)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rd_tap_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            scale_req_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            scale_req_reg <= scale_req_next;
            s1_vld_reg    <= (state_reg == S_READ);
            s2_vld_reg    <= s1_vld_reg;
            out_vld_reg   <= out_vld_next;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
                    if (&clr_addr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (samples.valid)
                    begin
                        rd_tap_reg <= TAP_AW'(n_eff - IDX_W'(1));
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_tap_reg <= rd_tap_reg - TAP_AW'(1);
                    if (rd_tap_reg == '0)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (drain_done)
                    begin
                        state_reg <= S_SCALE_OFF;
                    end
                end
                S_SCALE_OFF:
                begin
                    if (scale_sts.done)
                    begin
                        state_reg <= S_SCALE_DER;
                    end
                end
                S_SCALE_DER:
                begin
                    if (scale_sts.done)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (push_fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_in_reg <= samples.channel;
            mch_reg   <= ch_map[samples.channel];
            x_reg     <= smp_zx[SAMPLE_WIDTH-1:0];
            n_reg     <= ORD_W'(n_eff);
            acc_reg   <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= s2_neg_reg ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
        end
        s1_tap_reg <= rd_tap_reg;
        if (s1_vld_reg)
        begin
            prod_reg   <= ACC_W'(prod_c);
            s2_neg_reg <= j5[0];
        end
        if (drain_done)
        begin
            der_acc_reg <= acc_reg + ACC_W'(x_reg);
        end
        if ((state_reg == S_SCALE_OFF) && scale_sts.done)
        begin
            off_res_reg <= scale_sts.value;
            off_sat_reg <= scale_sts.sat;
        end
        if ((state_reg == S_SCALE_DER) && scale_sts.done)
        begin
            der_res_reg <= scale_sts.value;
            der_sat_reg <= scale_sts.sat;
        end
        if (push_fire)
        begin
            out_ch_reg  <= ch_in_reg;
            out_off_reg <= off_res_reg;
            out_der_reg <= der_res_reg;
            out_sat_reg <= off_sat_reg || der_sat_reg;
        end
    end

    assign samples.ready       = (state_reg == S_IDLE);
    assign results.valid       = out_vld_reg;
    assign results.out_channel = out_ch_reg;
    assign results.offset      = out_off_reg;
    assign results.derivative  = out_der_reg;
    assign results.saturated   = out_sat_reg;

    `BDD_ASSERT_SAME(a_ready_quiet, clk, rst_n, samples.ready, !s1_vld_reg && !s2_vld_reg && !scale_sts.busy)
    `BDD_ASSERT_SAME(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !mem_we)
    `BDD_ASSERT_SAME(a_done_in_scale, clk, rst_n, scale_sts.done, state_reg == S_SCALE_OFF || state_reg == S_SCALE_DER)
    `BDD_ASSERT_NEXT(a_push_loads, clk, rst_n, push_fire, out_vld_reg && state_reg == S_IDLE)

endmodule

### dv/tb_backward_difference_derivative.sv
// ----------------------------------------------------------------------------
// tb_backward_difference_derivative
// Self-checking testbench for the nth-order backward finite-difference block.
// A directed table covers the field extremes, rounding ties, order clamping,
// a zero and a full-scale reciprocal and saturation. Sixteen random phases then
// follow, each with fresh register values. Every result is compared field by
// field with its typed value if given, else a per-channel history predictor.
// ----------------------------------------------------------------------------
module tb_backward_difference_derivative;
    timeunit 1ns;
    timeprecision 1ps;

    import bdd_pkg::*;

    localparam int NUM_CHANNELS    = CHANNELS_DEF;
    localparam int ORDER_MAX       = MAX_ORDER_DEF;
    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int REPORT_LINES    = 20;
    localparam int NUM_DIRECTED    = 26;

    typedef enum logic [PADDR_W-1:0] {
        REG_DIFF_ORDER   = PADDR_W'(0),
        REG_INV_DT_POWER = PADDR_W'(8)
    } reg_addr_e;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       out_channel;
        logic signed [RESULT_W-1:0] offset;
        logic signed [RESULT_W-1:0] derivative;
        logic                       saturated;
    } deriv_result_t;

    typedef struct packed {
        row_kind_e              kind;
        logic [ORDER_REG_W-1:0] order;
        logic [INV_DT_W-1:0]    inv_dt;
        logic [CHANNEL_W-1:0]   ch;
        logic [SAMPLE_W-1:0]    smp;
        logic                   known;
        deriv_result_t          want;
    } stim_row_t;

    localparam deriv_result_t NO_WANT = '0;

    // Register writes sit between sample rows; typed expectations are given only
    // where the value follows directly from the history and the scale factor.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd0, 32'h7FFF_FFFF, 1'b1,
          '{4'd0, 64'h0, 64'h7FFF_FFFF, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd0, 32'h8000_0000, 1'b1,
          '{4'd0, 64'hFFFF_FFFF_8000_0001, 64'hFFFF_FFFF_0000_0001, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd15, 32'hFFFF_FFFF, 1'b1,
          '{4'd15, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd0, 32'h0000_0000, 1'b1,
          '{4'd0, 64'h8000_0000, 64'h8000_0000, 1'b0}},
        '{ROW_WRITE, 4'd1, 48'h0000_0000_0001, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd1, 32'h0000_8000, 1'b1,
          '{4'd1, 64'h0, 64'h1, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd2, 32'hFFFF_8000, 1'b1,
          '{4'd2, 64'h0, 64'h0, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd1, 32'hFFFF_8000, 1'b1,
          '{4'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
        '{ROW_WRITE, 4'd1, 48'hFFFF_FFFF_FFFF, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd7, 32'h8000_0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd7, 32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd7, 32'h8000_0000, 1'b0, NO_WANT},
        '{ROW_WRITE, 4'd8, 48'hFFFF_FFFF_FFFF, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h8000_0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h8000_0000, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{ROW_WRITE, 4'd0, 48'h0000_0001_0000, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd3, 32'h1234_5678, 1'b0, NO_WANT},
        '{ROW_WRITE, 4'd15, 48'h0000_0001_8000, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'hDEAD_BEEF, 1'b0, NO_WANT},
        '{ROW_WRITE, 4'd9, 48'h0000_0000_0000, 4'd0, 32'h0, 1'b0, NO_WANT},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd4, 32'h7FFF_FFFF, 1'b1,
          '{4'd4, 64'h0, 64'h0, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd9, 32'h5555_5555, 1'b1,
          '{4'd9, 64'h0, 64'h0, 1'b0}},
        '{ROW_SAMPLE, 4'd0, 48'd0, 4'd14, 32'hAAAA_AAAA, 1'b0, NO_WANT}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bdd_in_if  sample_if ();
    bdd_out_if result_if ();

    backward_difference_derivative dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_if),
        .results (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: register copies and the per-channel sample history.
    logic [ORDER_REG_W-1:0]     cfg_order;
    logic [INV_DT_W-1:0]        cfg_inv_dt;
    logic signed [SAMPLE_W-1:0] tap_store [NUM_CHANNELS][ORDER_MAX];

    deriv_result_t expected_results [$];

    int  walk_val  [NUM_CHANNELS];
    int  walk_step [NUM_CHANNELS];
    bit  idle_en = 1'b1;
    int  mismatch_count = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  saturated_results = 0;
    int  settings_used = 0;
    int  stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Rescales a Q16.16 sum by the Q32.16 reciprocal into saturated Q48.16,
    // rounding to nearest with ties towards plus infinity.
    function automatic logic signed [RESULT_W-1:0] scale_to_q48(input longint v,
                                                                output logic clipped);
        logic signed [127:0] prod;
        prod = v;
        prod = prod * $signed({80'd0, cfg_inv_dt});
        prod = (prod + 128'sd32768) >>> 16;
        clipped = (prod[127:63] != {65{prod[127]}});
        if (!clipped)
            return prod[63:0];
        return prod[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic deriv_result_t predict_derivative(input logic [CHANNEL_W-1:0] ch,
                                                         input logic signed [SAMPLE_W-1:0] x);
        int            taps;
        longint        coef;
        longint        hist_sum;
        logic          sat_off;
        logic          sat_der;
        deriv_result_t r;
        if (cfg_order == 0)
            taps = 1;
        else if (cfg_order > ORDER_MAX)
            taps = ORDER_MAX;
        else
            taps = cfg_order;
        coef = 1;
        hist_sum = 0;
        for (int j = 1; j <= taps; j++)
        begin
            coef = coef * longint'(taps - j + 1) / j;
            if (j % 2 == 1)
                hist_sum -= coef * longint'(tap_store[ch][j - 1]);
            else
                hist_sum += coef * longint'(tap_store[ch][j - 1]);
        end
        r.out_channel = ch;
        r.offset      = scale_to_q48(hist_sum, sat_off);
        r.derivative  = scale_to_q48(hist_sum + longint'(x), sat_der);
        r.saturated   = sat_off | sat_der;
        // Taps beyond the current order keep their old contents.
        for (int j = taps - 1; j > 0; j--)
            tap_store[ch][j] = tap_store[ch][j - 1];
        tap_store[ch][0] = x;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        if (mismatch_count < REPORT_LINES)
            $display("[%0t] mismatch on result %0d, %s: got %h, expected %h",
                     $time, results_checked, field, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] x,
                               input logic known, input deriv_result_t want);
        int            gap;
        deriv_result_t predicted;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            sample_if.valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.channel <= ch;
        sample_if.sample  <= x;
        do
            @(posedge clk);
        while (!sample_if.ready);
        predicted = predict_derivative(ch, $signed(x));
        expected_results.push_back(known ? want : predicted);
        samples_sent++;
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic apb_write(input reg_addr_e addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr)
            REG_DIFF_ORDER:   cfg_order  = data[ORDER_REG_W-1:0];
            REG_INV_DT_POWER: cfg_inv_dt = data[INV_DT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers are only written once every outstanding result has come back.
    task automatic set_config(input logic [ORDER_REG_W-1:0] order,
                              input logic [INV_DT_W-1:0] inv_dt);
        wait_drained();
        apb_write(REG_DIFF_ORDER, PDATA_W'(order));
        apb_write(REG_INV_DT_POWER, PDATA_W'(inv_dt));
        settings_used++;
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        deriv_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none expected, out_channel",
                                64'(result_if.out_channel), '0);
            else
            begin
                want = expected_results.pop_front();
                if (result_if.out_channel !== want.out_channel)
                    report_mismatch("out_channel", 64'(result_if.out_channel),
                                    64'(want.out_channel));
                if (result_if.offset !== want.offset)
                    report_mismatch("offset", result_if.offset, want.offset);
                if (result_if.derivative !== want.derivative)
                    report_mismatch("derivative", result_if.derivative, want.derivative);
                if (result_if.saturated !== want.saturated)
                    report_mismatch("saturated", 64'(result_if.saturated),
                                    64'(want.saturated));
                if (want.saturated)
                    saturated_results++;
            end
            results_checked++;
        end
    end

    // Ends the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin : watchdog
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) || psel)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] timeout: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        logic [ORDER_REG_W-1:0] order;
        logic [INV_DT_W-1:0]    inv_dt;
        logic [CHANNEL_W-1:0]   ch;
        logic [SAMPLE_W-1:0]    x;
        int                     pick;
        rst_n             <= 1'b0;
        sample_if.valid   <= 1'b0;
        sample_if.channel <= '0;
        sample_if.sample  <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cfg_order  = ORDER_REG_W'(1);
        cfg_inv_dt = INV_DT_W'(65536);
        foreach (tap_store[c, t])
            tap_store[c][t] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE)
                set_config(DIRECTED_ROWS[i].order, DIRECTED_ROWS[i].inv_dt);
            else
                send_sample(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].smp,
                            DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       order = '0;
                1:       order = ORDER_REG_W'($urandom_range(ORDER_MAX + 1, 15));
                default: order = ORDER_REG_W'($urandom_range(1, ORDER_MAX));
            endcase
            case ($urandom_range(0, 7))
                0:       inv_dt = '1;
                1:       inv_dt = INV_DT_W'({$urandom, $urandom});
                2:       inv_dt = INV_DT_W'($urandom_range(0, 65536));
                6:       inv_dt = INV_DT_W'({8'($urandom), $urandom});
                7:       inv_dt = INV_DT_W'(65536);
                default: inv_dt = INV_DT_W'($urandom_range(16384, 262144));
            endcase
            set_config(order, inv_dt);
            // The closing phase runs without gaps or stalls, as do a few others.
            idle_en = (phase != NUM_PHASES - 1) && (phase % 5 != 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                ch = CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    // Smooth per-channel ramps give results well inside the range.
                    if ($urandom_range(0, 15) == 0)
                    begin
                        walk_val[ch]  = $urandom;
                        walk_step[ch] = int'($urandom_range(0, 131072)) - 65536;
                    end
                    walk_val[ch] += walk_step[ch];
                    x = walk_val[ch];
                end
                else if (pick < 8)
                    x = $urandom;
                else if (pick == 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       x = 32'h7FFF_FFFF;
                        1:       x = 32'h8000_0000;
                        2:       x = '0;
                        default: x = '1;
                    endcase
                end
                else
                    x = 32'(int'($urandom_range(0, 131072)) - 65536);
                send_sample(ch, x, 1'b0, NO_WANT);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d samples under %0d register settings.",
                 samples_sent, settings_used);
        $display("%0d results checked, %0d of them saturated, %0d mismatches.",
                 results_checked, saturated_results, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
